// ----- rtl/pbk_pkg.sv -----
// shared constants, types and register codes of the per-bin kalman smoother
// no dependencies; imported by pbk_div and the top level
package pbk_pkg;

  // configuration of the design (NUM_BINS must be a power of two up to 4096)
  localparam int NUM_BINS       = 4096;
  localparam int ADDR_BITS      = $clog2(NUM_BINS);
  localparam int BIN_FIELD_BITS = 12;
  localparam int SAMPLE_BITS    = 20;
  localparam int GAIN_FRAC_BITS = 18;
  localparam int PWR_BITS       = 48;
  localparam int KR_BITS        = 16;
  localparam int KR_FRAC_BITS   = 8;
  localparam int CFG_IDX_BITS   = 2;

  // derived widths
  localparam int GAIN_BITS  = GAIN_FRAC_BITS + 1;
  localparam int DEN_BITS   = PWR_BITS + 1;
  localparam int REM_BITS   = PWR_BITS + 2;
  localparam int DIFF_BITS  = SAMPLE_BITS + 1;
  localparam int SQ_BITS    = 2 * DIFF_BITS;
  localparam int THRP_BITS  = PWR_BITS + KR_BITS;
  localparam int THR_BITS   = THRP_BITS - KR_FRAC_BITS;
  localparam int BLEND_BITS = GAIN_BITS + SAMPLE_BITS;
  localparam int GPROD_BITS = PWR_BITS + GAIN_BITS;

  localparam logic [GAIN_BITS-1:0]  GAIN_ONE   = GAIN_BITS'(1) << GAIN_FRAC_BITS;
  localparam logic [BLEND_BITS-1:0] BLEND_HALF = BLEND_BITS'(1) << (GAIN_FRAC_BITS - 1);

  // pipeline stage numbering
  localparam int STG_A       = 0;
  localparam int STG_B       = 1;
  localparam int STG_C       = 2;
  localparam int STG_D       = 3;
  localparam int DIV_FIRST   = 4;
  localparam int DIV_STEPS   = GAIN_FRAC_BITS;
  localparam int STG_G       = DIV_FIRST + DIV_STEPS;
  localparam int STG_M       = STG_G + 1;
  localparam int PIPE_STAGES = STG_M + 1;

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_PATTERN_MODE = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_NOISE_FLOOR  = CFG_IDX_BITS'(1);
  localparam logic [CFG_IDX_BITS-1:0] REG_KRATIO       = CFG_IDX_BITS'(2);

  typedef logic [ADDR_BITS-1:0]          addr_t;
  typedef logic signed [SAMPLE_BITS-1:0] smp_t;
  typedef logic [PWR_BITS-1:0]           pwr_t;
  typedef logic [GAIN_BITS-1:0]          gain_t;

  // item context that travels with every stage
  typedef struct packed {
    addr_t bin;
    smp_t  cre;
    smp_t  cim;
    smp_t  pre;
    smp_t  pim;
    pwr_t  noise;
    pwr_t  sum;
    logic  restart;
    logic  motion;
    logic  dz;
  } item_t;

  // per-bin stored state
  typedef struct packed {
    pwr_t cov;
    pwr_t pcov;
    smp_t re;
    smp_t im;
  } bin_state_t;

endpackage

// ----- rtl/pbk_div.sv -----
// pipelined restoring divider for the kalman gain, one quotient bit per stage
// depends on pbk_pkg; stage enables come from the top level pipeline control
module pbk_div (
  input  logic                              clk,
  input  logic [pbk_pkg::DIV_STEPS-1:0]     en,
  input  logic [pbk_pkg::DEN_BITS-1:0]      den_i,
  input  logic [pbk_pkg::DEN_BITS-1:0]      rem_i,
  input  logic [pbk_pkg::GAIN_BITS-1:0]     quo_i,
  output logic [pbk_pkg::GAIN_BITS-1:0]     quo_o
);
  import pbk_pkg::*;

  logic [DEN_BITS-1:0]  den_r [DIV_STEPS];
  logic [DEN_BITS-1:0]  rem_r [DIV_STEPS];
  logic [GAIN_BITS-1:0] quo_r [DIV_STEPS];
  logic [DEN_BITS-1:0]  rem_nxt [DIV_STEPS];
  logic [GAIN_BITS-1:0] quo_nxt [DIV_STEPS];

  // one shift, compare and subtract per stage
  always_comb begin
    logic [DEN_BITS-1:0]  den_in;
    logic [DEN_BITS-1:0]  rem_in;
    logic [GAIN_BITS-1:0] quo_in;
    logic [REM_BITS-1:0]  rem2;
    for (int k = 0; k < DIV_STEPS; k++) begin
      den_in = (k == 0) ? den_i : den_r[k-1];
      rem_in = (k == 0) ? rem_i : rem_r[k-1];
      quo_in = (k == 0) ? quo_i : quo_r[k-1];
      rem2   = {rem_in, 1'b0};
      if (rem2 >= {1'b0, den_in}) begin
        rem_nxt[k] = DEN_BITS'(rem2 - {1'b0, den_in});
        quo_nxt[k] = {quo_in[GAIN_BITS-2:0], 1'b1};
      end else begin
        rem_nxt[k] = rem2[DEN_BITS-1:0];
        quo_nxt[k] = {quo_in[GAIN_BITS-2:0], 1'b0};
      end
    end
  end

  // stage registers
  always_ff @(posedge clk) begin
    for (int k = 0; k < DIV_STEPS; k++) begin
      if (en[k]) begin
        den_r[k] <= (k == 0) ? den_i : den_r[k-1];
        rem_r[k] <= rem_nxt[k];
        quo_r[k] <= quo_nxt[k];
      end
    end
  end

  assign quo_o = quo_r[DIV_STEPS-1];

endmodule

// ----- rtl/per_bin_kalman_with_motion_reset_top.sv -----
// top level of the per-bin kalman smoother with motion reset
// depends on pbk_pkg and pbk_div; holds the per-bin state memory
//
// One item enters per clock while bins differ and out_stall is low; a result
// appears after stages a to d, the 18-stage long division that forms the gain,
// and stages g and m. An item whose bin is still in flight is held at in_stall
// until the earlier item of that bin has written its state back.
// Per-bin state is not cleared at reset: the first item of each bin should
// carry restart. Configuration writes take effect at once and are meant for
// idle periods.
module per_bin_kalman_with_motion_reset_top (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [pbk_pkg::BIN_FIELD_BITS-1:0]    in_bin_index,
  input  logic signed [pbk_pkg::SAMPLE_BITS-1:0] in_cur_re,
  input  logic signed [pbk_pkg::SAMPLE_BITS-1:0] in_cur_im,
  input  logic [pbk_pkg::PWR_BITS-1:0]          in_noise_level,
  input  logic                                  in_restart,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [pbk_pkg::SAMPLE_BITS-1:0] out_re,
  output logic signed [pbk_pkg::SAMPLE_BITS-1:0] out_im,
  output logic                                  out_motion,
  input  logic                                  cfg_we,
  input  logic [pbk_pkg::CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [pbk_pkg::PWR_BITS-1:0]          cfg_wdata
);
  import pbk_pkg::*;

  // configuration registers
  logic               pattern_mode_r;
  pwr_t               noise_floor_r;
  logic [KR_BITS-1:0] kratio_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_mode_r <= 1'b0;
      noise_floor_r  <= PWR_BITS'(1);
      kratio_r       <= KR_BITS'(1024);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PATTERN_MODE: pattern_mode_r <= cfg_wdata[0];
        REG_NOISE_FLOOR:  noise_floor_r  <= cfg_wdata;
        REG_KRATIO:       kratio_r       <= cfg_wdata[KR_BITS-1:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic [PIPE_STAGES-1:0] v_r;
  logic [PIPE_STAGES:0]   en;
  item_t                  pl_r   [PIPE_STAGES];
  item_t                  pl_nxt [PIPE_STAGES];
  logic                   hazard;
  logic                   accept;
  addr_t                  in_addr;
  logic                   out_valid_r;
  logic                   wr_en;

  assign in_addr = in_bin_index[ADDR_BITS-1:0];

  always_comb begin
    en[PIPE_STAGES] = !out_valid_r || !out_stall;
    for (int k = PIPE_STAGES - 1; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  // same-bin items in flight wait for the write-back
  always_comb begin
    hazard = 1'b0;
    for (int k = 0; k < PIPE_STAGES; k++) begin
      if (v_r[k] && pl_r[k].bin == in_addr) hazard = 1'b1;
    end
  end

  assign in_stall = !en[0] || hazard;
  assign accept   = in_valid && !in_stall;
  assign wr_en    = en[PIPE_STAGES] && v_r[PIPE_STAGES-1];

  // per-bin state memory
  bin_state_t mem [NUM_BINS];
  bin_state_t rd_r;
  bin_state_t wr_state;

  always_ff @(posedge clk) begin
    if (en[STG_A]) rd_r <= mem[in_addr];
    if (wr_en) mem[pl_r[STG_M].bin] <= wr_state;
  end

  // stage-local registers
  logic [THR_BITS-1:0]         b_thr_r, c_thr_r;
  logic signed [DIFF_BITS-1:0] b_dre_r, b_dim_r;
  logic [SQ_BITS-1:0]          c_sqre_r, c_sqim_r;
  logic [DEN_BITS-1:0]         c_den_r, d_den_r, d_rem_r;
  gain_t                       d_quo_r, g_gain_r, m_gain_r, div_quo;
  pwr_t                        m_a_r, m_covn_r;
  logic [BLEND_BITS-1:0]       m_pcre_r, m_ppre_r, m_pcim_r, m_ppim_r;

  logic [THR_BITS-1:0]         b_thr_nxt;
  logic signed [DIFF_BITS-1:0] b_dre_nxt, b_dim_nxt;
  logic [SQ_BITS-1:0]          c_sqre_nxt, c_sqim_nxt;
  logic [DEN_BITS-1:0]         c_den_nxt, d_rem_nxt;
  gain_t                       d_quo_nxt, g_gain_nxt;
  pwr_t                        m_a_nxt, m_covn_nxt;
  logic [BLEND_BITS-1:0]       m_pcre_nxt, m_ppre_nxt, m_pcim_nxt, m_ppim_nxt;

  // stage datapath
  always_comb begin
    logic [PWR_BITS:0]          sum_w;
    logic [THRP_BITS-1:0]       thr_p;
    logic [DIFF_BITS-1:0]       mag_re, mag_im;
    logic [GPROD_BITS-1:0]      pa, pc;
    gain_t                      gc;
    logic [SAMPLE_BITS-1:0]     ucre, ucim, upre, upim;
    for (int k = 1; k < PIPE_STAGES; k++) pl_nxt[k] = pl_r[k-1];

    // stage a: input capture and noise floor
    pl_nxt[STG_A].bin     = in_addr;
    pl_nxt[STG_A].cre     = in_cur_re;
    pl_nxt[STG_A].cim     = in_cur_im;
    pl_nxt[STG_A].pre     = '0;
    pl_nxt[STG_A].pim     = '0;
    pl_nxt[STG_A].noise   = (pattern_mode_r && in_noise_level < noise_floor_r) ?
                            noise_floor_r : in_noise_level;
    pl_nxt[STG_A].sum     = '0;
    pl_nxt[STG_A].restart = in_restart;
    pl_nxt[STG_A].motion  = 1'b0;
    pl_nxt[STG_A].dz      = 1'b0;

    // stage b: threshold product, differences, covariance sum
    pl_nxt[STG_B].pre = rd_r.re;
    pl_nxt[STG_B].pim = rd_r.im;
    sum_w = {1'b0, rd_r.cov} + {1'b0, rd_r.pcov};
    pl_nxt[STG_B].sum = sum_w[PWR_BITS] ? '1 : sum_w[PWR_BITS-1:0];
    thr_p     = pl_r[STG_A].noise * kratio_r;
    b_thr_nxt = thr_p[THRP_BITS-1:KR_FRAC_BITS];
    b_dre_nxt = DIFF_BITS'(pl_r[STG_A].cre) - DIFF_BITS'(rd_r.re);
    b_dim_nxt = DIFF_BITS'(pl_r[STG_A].cim) - DIFF_BITS'(rd_r.im);

    // stage c: squared differences and gain denominator
    mag_re     = b_dre_r[DIFF_BITS-1] ? DIFF_BITS'(-b_dre_r) : DIFF_BITS'(b_dre_r);
    mag_im     = b_dim_r[DIFF_BITS-1] ? DIFF_BITS'(-b_dim_r) : DIFF_BITS'(b_dim_r);
    c_sqre_nxt = mag_re * mag_re;
    c_sqim_nxt = mag_im * mag_im;
    c_den_nxt  = {1'b0, pl_r[STG_B].sum} + {1'b0, pl_r[STG_B].noise};

    // stage d: motion decision and first quotient bit
    pl_nxt[STG_D].motion = pl_r[STG_C].restart ||
                           THR_BITS'(c_sqre_r) > c_thr_r ||
                           THR_BITS'(c_sqim_r) > c_thr_r;
    pl_nxt[STG_D].dz = (c_den_r == '0);
    if ({1'b0, pl_r[STG_C].sum} >= c_den_r) begin
      d_rem_nxt = {1'b0, pl_r[STG_C].sum} - c_den_r;
      d_quo_nxt = GAIN_BITS'(1);
    end else begin
      d_rem_nxt = {1'b0, pl_r[STG_C].sum};
      d_quo_nxt = '0;
    end

    // stage g: gain clamp, zero gain on a zero denominator
    if (pl_r[STG_G-1].dz)         g_gain_nxt = '0;
    else if (div_quo > GAIN_ONE)  g_gain_nxt = GAIN_ONE;
    else                          g_gain_nxt = div_quo;

    // stage m: gain products
    gc         = GAIN_ONE - g_gain_r;
    pa         = pl_r[STG_G].noise * g_gain_r;
    pc         = pl_r[STG_G].sum * gc;
    m_a_nxt    = pa[GAIN_FRAC_BITS +: PWR_BITS];
    m_covn_nxt = pc[GAIN_FRAC_BITS +: PWR_BITS];
    ucre = {~pl_r[STG_G].cre[SAMPLE_BITS-1], pl_r[STG_G].cre[SAMPLE_BITS-2:0]};
    ucim = {~pl_r[STG_G].cim[SAMPLE_BITS-1], pl_r[STG_G].cim[SAMPLE_BITS-2:0]};
    upre = {~pl_r[STG_G].pre[SAMPLE_BITS-1], pl_r[STG_G].pre[SAMPLE_BITS-2:0]};
    upim = {~pl_r[STG_G].pim[SAMPLE_BITS-1], pl_r[STG_G].pim[SAMPLE_BITS-2:0]};
    m_pcre_nxt = g_gain_r * ucre;
    m_ppre_nxt = gc * upre;
    m_pcim_nxt = g_gain_r * ucim;
    m_ppim_nxt = gc * upim;
  end

  // divider
  pbk_div u_div (
    .clk   (clk),
    .en    (en[DIV_FIRST +: DIV_STEPS]),
    .den_i (d_den_r),
    .rem_i (d_rem_r),
    .quo_i (d_quo_r),
    .quo_o (div_quo)
  );

  // final blend, process covariance and motion select
  smp_t ore_w, oim_w;
  always_comb begin
    logic [GPROD_BITS-1:0]  pp;
    logic [BLEND_BITS-1:0]  acc_re, acc_im;
    logic [SAMPLE_BITS-1:0] bre, bim;
    pp     = m_a_r * m_gain_r;
    acc_re = m_pcre_r + m_ppre_r + BLEND_HALF;
    acc_im = m_pcim_r + m_ppim_r + BLEND_HALF;
    bre    = acc_re[GAIN_FRAC_BITS +: SAMPLE_BITS];
    bim    = acc_im[GAIN_FRAC_BITS +: SAMPLE_BITS];
    if (pl_r[STG_M].motion) begin
      ore_w         = pl_r[STG_M].cre;
      oim_w         = pl_r[STG_M].cim;
      wr_state.cov  = pl_r[STG_M].noise;
      wr_state.pcov = pl_r[STG_M].noise;
    end else begin
      ore_w         = {~bre[SAMPLE_BITS-1], bre[SAMPLE_BITS-2:0]};
      oim_w         = {~bim[SAMPLE_BITS-1], bim[SAMPLE_BITS-2:0]};
      wr_state.cov  = m_covn_r;
      wr_state.pcov = pp[GAIN_FRAC_BITS +: PWR_BITS];
    end
    wr_state.re = ore_w;
    wr_state.im = oim_w;
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (en[STG_A]) v_r[STG_A] <= accept;
      for (int k = 1; k < PIPE_STAGES; k++) begin
        if (en[k]) v_r[k] <= v_r[k-1];
      end
      if (en[PIPE_STAGES]) out_valid_r <= v_r[PIPE_STAGES-1];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    for (int k = 0; k < PIPE_STAGES; k++) begin
      if (en[k]) pl_r[k] <= pl_nxt[k];
    end
    if (en[STG_B]) begin
      b_thr_r <= b_thr_nxt;
      b_dre_r <= b_dre_nxt;
      b_dim_r <= b_dim_nxt;
    end
    if (en[STG_C]) begin
      c_thr_r  <= b_thr_r;
      c_sqre_r <= c_sqre_nxt;
      c_sqim_r <= c_sqim_nxt;
      c_den_r  <= c_den_nxt;
    end
    if (en[STG_D]) begin
      d_den_r <= c_den_r;
      d_rem_r <= d_rem_nxt;
      d_quo_r <= d_quo_nxt;
    end
    if (en[STG_G]) g_gain_r <= g_gain_nxt;
    if (en[STG_M]) begin
      m_gain_r <= g_gain_r;
      m_a_r    <= m_a_nxt;
      m_covn_r <= m_covn_nxt;
      m_pcre_r <= m_pcre_nxt;
      m_ppre_r <= m_ppre_nxt;
      m_pcim_r <= m_pcim_nxt;
      m_ppim_r <= m_ppim_nxt;
    end
    if (en[PIPE_STAGES]) begin
      out_re     <= ore_w;
      out_im     <= oim_w;
      out_motion <= pl_r[STG_M].motion;
    end
  end

  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  logic dup_bin;
  always_comb begin
    dup_bin = 1'b0;
    for (int i = 0; i < PIPE_STAGES; i++) begin
      for (int j = i + 1; j < PIPE_STAGES; j++) begin
        if (v_r[i] && v_r[j] && pl_r[i].bin == pl_r[j].bin) dup_bin = 1'b1;
      end
    end
  end

  // never two items of one bin in flight
  a_no_dup_bin: assert property (@(posedge clk) disable iff (!rst_n) !dup_bin)
    else $error("two items of one bin in flight");

  // clamped gain never exceeds one
  a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[STG_M] |-> m_gain_r <= GAIN_ONE)
    else $error("gain above one");

  // an accepted item lands in the first stage with its bin
  a_accept_fill: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> v_r[STG_A] && pl_r[STG_A].bin == $past(in_addr))
    else $error("accepted item lost at entry");

  // a zero denominator only arises with zero noise
  a_dz_noise: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[STG_D] && pl_r[STG_D].dz |-> pl_r[STG_D].noise == '0)
    else $error("zero denominator with nonzero noise");
`endif

endmodule
